// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types, codes and word layouts of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int NUM_THREADS_DEF = 16;

    localparam int ID_W      = 4;
    localparam int DEPTH_W   = 8;
    localparam int QC_W      = 5;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Input word layout.
    localparam int IN_OP_LSB  = 0;
    localparam int IN_TID_LSB = 3;

    // Output word layout.
    localparam int OUT_RUN_LSB  = 0;
    localparam int OUT_RV_BIT   = 4;
    localparam int OUT_SW_BIT   = 5;
    localparam int OUT_RELV_BIT = 6;
    localparam int OUT_RELT_LSB = 7;
    localparam int OUT_REJ_BIT  = 11;
    localparam int OUT_QC_LSB   = 12;

    typedef enum logic [2:0] {
        OP_MAKE_READY  = 3'd0,
        OP_TICK        = 3'd1,
        OP_YIELD       = 3'd2,
        OP_EXIT        = 3'd3,
        OP_WAKE        = 3'd4,
        OP_BLOCK       = 3'd5,
        OP_EN_PREEMPT  = 3'd6,
        OP_DIS_PREEMPT = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_FREE       = 3'd0,
        ST_READY      = 3'd1,
        ST_RUNNING    = 3'd2,
        ST_BLOCKED    = 3'd3,
        ST_TERMINATED = 3'd4
    } t_status;

endpackage

// File: design/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/round_robin_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Round-robin thread scheduler with a status table and a FIFO ready queue.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one request word per item: operation in bits 2:0,
//   thread number in bits 6:3. The master stream returns exactly one result
//   word per request. The cfg write channel sets the idle thread number and
//   is always ready; write it only while no request is in flight.
//   Thread status and the ready queue live in two RAMs with registered reads.
//   Make ready, wake and block run a status read, then an update; tick
//   without a switch and the preemption controls go straight to the result;
//   an item that runs the scheduling decision steps through the status reads
//   for the pending release and for the running thread, then the switch.
//   One item is in work at a time, so the next word is accepted once the
//   previous one has been handed to the output register.
//   When the receiver stalls, the result waits in the output register and
//   the block holds its final step until the register is free.
//   After reset all threads read as free through per-entry valid bits, the
//   queue is empty, no thread runs and the idle thread is 0.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core #(
    parameter int NUM_THREADS = rrts_pkg::NUM_THREADS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // cfg: idle_thread_id
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rrts_pkg::ID_W-1:0]     i_cfg_data,
    // tdata: operation[2:0], thread_id[6:3], zero[7]
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [rrts_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tdata: running_thread[3:0], running_valid[4], switched[5],
    //        release_valid[6], release_thread[10:7], rejected[11],
    //        queue_count[16:12], zero[23:17]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [rrts_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    import rrts_pkg::*;

    localparam int TW = $clog2(NUM_THREADS);
    localparam int CW = $clog2(NUM_THREADS + 1);
    localparam logic [CW-1:0] FULL = CW'(NUM_THREADS);
    localparam logic [TW-1:0] LAST = TW'(NUM_THREADS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_FIN  = 6'b000100,
        S_PEND = 6'b001000,
        S_DEC  = 6'b010000,
        S_RUN  = 6'b100000
    } t_state;

    function automatic logic in_range(input logic [ID_W-1:0] t);
        return 32'(t) < 32'(NUM_THREADS);
    endfunction

    function automatic logic [TW-1:0] next_ptr(input logic [TW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [ID_W-1:0]     r_tid, n_tid;
    logic [ID_W-1:0]     r_idle;
    logic [ID_W-1:0]     r_cur, n_cur;
    logic                r_cv, n_cv;
    logic [ID_W-1:0]     r_pend, n_pend;
    logic                r_pv, n_pv;
    logic                r_pre, n_pre;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic                r_act, n_act;
    logic                r_force, n_force;
    logic [TW-1:0]       r_head, n_head;
    logic [TW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_count, n_count;
    logic [NUM_THREADS-1:0] r_stv;
    logic                r_st_ok;
    logic                r_due, n_due;
    logic                r_rel_v, n_rel_v;
    logic [ID_W-1:0]     r_rel_t, n_rel_t;
    logic [ID_W-1:0]     r_nxt, n_nxt;
    logic                r_prev_term, n_prev_term;
    logic [M_TDATA_W-1:0] r_out;
    logic                r_ovalid;

    logic                in_fire, slot_free, load, go;
    t_op                 in_op;
    logic [ID_W-1:0]     in_tid;
    logic [DEPTH_W-1:0]  depth_dec;
    logic                out_sw, out_rej, requeue;
    t_status             st_val, prev_st;
    logic                st_re, st_we, st_we_ok;
    logic [ID_W-1:0]     st_rid, st_wid;
    t_status             st_wdata;
    logic [2:0]          st_rdata;
    logic                fq_we, fq_re;
    logic [ID_W-1:0]     fq_wdata, fq_rdata;
    logic [M_TDATA_W-1:0] out_word;

    assign in_op  = t_op'(i_s_axis_tdata[IN_OP_LSB +: 3]);
    assign in_tid = i_s_axis_tdata[IN_TID_LSB +: ID_W];

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free       = !r_ovalid || i_m_axis_tready;
    assign st_val          = r_st_ok ? t_status'(st_rdata) : ST_FREE;
    assign st_we_ok        = st_we && in_range(st_wid);

    rrts_ram #(
        .WIDTH (3),
        .DEPTH (NUM_THREADS)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (st_we_ok),
        .i_waddr (TW'(st_wid)),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (TW'(st_rid)),
        .o_rdata (st_rdata)
    );

    rrts_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_THREADS)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (fq_we),
        .i_waddr (r_tail),
        .i_wdata (fq_wdata),
        .i_re    (fq_re),
        .i_raddr (r_head),
        .o_rdata (fq_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_tid       = r_tid;
        n_cur       = r_cur;
        n_cv        = r_cv;
        n_pend      = r_pend;
        n_pv        = r_pv;
        n_pre       = r_pre;
        n_depth     = r_depth;
        n_act       = r_act;
        n_force     = r_force;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_due       = r_due;
        n_rel_v     = r_rel_v;
        n_rel_t     = r_rel_t;
        n_nxt       = r_nxt;
        n_prev_term = r_prev_term;
        st_re       = 1'b0;
        st_rid      = r_tid;
        st_we       = 1'b0;
        st_wid      = r_tid;
        st_wdata    = ST_FREE;
        fq_we       = 1'b0;
        fq_re       = 1'b0;
        fq_wdata    = r_cur;
        load        = 1'b0;
        go          = 1'b0;
        out_sw      = 1'b0;
        out_rej     = 1'b0;
        requeue     = 1'b0;
        prev_st     = ST_FREE;
        depth_dec   = (r_depth != '0) ? r_depth - 1'b1 : r_depth;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op    = in_op;
                    n_tid   = in_tid;
                    n_rel_v = 1'b0;
                    n_rel_t = '0;
                    n_state = S_FIN;
                    unique case (in_op)
                        OP_MAKE_READY, OP_WAKE, OP_BLOCK: begin
                            st_re   = 1'b1;
                            st_rid  = in_tid;
                            n_state = S_EXEC;
                        end
                        OP_TICK: begin
                            go      = (r_pre && r_depth == '0 && r_act) || r_force;
                            n_force = 1'b0;
                        end
                        OP_YIELD, OP_EXIT: begin
                            // The running thread's status is written here, before the
                            // decision reads it back from S_PEND.
                            if (in_op == OP_EXIT && r_cv) begin
                                st_we    = 1'b1;
                                st_wid   = r_cur;
                                st_wdata = ST_TERMINATED;
                            end
                            go      = 1'b1;
                            n_act   = 1'b1;
                            n_force = 1'b0;
                        end
                        OP_EN_PREEMPT: begin
                            n_depth = depth_dec;
                            if (depth_dec == '0 && !r_pre) begin
                                n_pre = 1'b1;
                                n_act = 1'b1;
                            end
                        end
                        OP_DIS_PREEMPT: begin
                            if (r_depth != '1) begin
                                n_depth = r_depth + 1'b1;
                            end
                            n_pre = 1'b0;
                        end
                    endcase
                    if (go) begin
                        n_due   = r_pv && (!r_cv || r_pend != r_cur);
                        st_re   = 1'b1;
                        st_rid  = r_pend;
                        n_state = S_PEND;
                    end
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_op)
                        OP_MAKE_READY, OP_WAKE: begin
                            if (in_range(r_tid) && r_count != FULL &&
                                ((r_op == OP_MAKE_READY && st_val != ST_READY) ||
                                 (r_op == OP_WAKE && st_val == ST_BLOCKED))) begin
                                fq_we    = 1'b1;
                                fq_wdata = r_tid;
                                st_we    = 1'b1;
                                st_wid   = r_tid;
                                st_wdata = ST_READY;
                                n_tail   = next_ptr(r_tail);
                                n_count  = r_count + 1'b1;
                            end else begin
                                out_rej = 1'b1;
                            end
                        end
                        OP_BLOCK: begin
                            if (in_range(r_tid) && st_val == ST_RUNNING) begin
                                st_we    = 1'b1;
                                st_wid   = r_tid;
                                st_wdata = ST_BLOCKED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PEND: begin
                // Release the thread that terminated one switch ago.
                if (r_due) begin
                    if (st_val == ST_TERMINATED) begin
                        st_we    = 1'b1;
                        st_wid   = r_pend;
                        st_wdata = ST_FREE;
                        n_rel_v  = 1'b1;
                        n_rel_t  = r_pend;
                    end
                    n_pv = 1'b0;
                end
                st_re   = 1'b1;
                st_rid  = r_cur;
                fq_re   = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                prev_st = r_cv ? st_val : ST_FREE;
                requeue = r_cv && prev_st == ST_RUNNING && r_cur != r_idle &&
                          r_count != FULL;
                if (requeue) begin
                    fq_we    = 1'b1;
                    fq_wdata = r_cur;
                    st_we    = 1'b1;
                    st_wid   = r_cur;
                    st_wdata = ST_READY;
                    n_tail   = next_ptr(r_tail);
                end
                if (r_count != '0) begin
                    n_nxt  = fq_rdata;
                    n_head = next_ptr(r_head);
                    if (!requeue) begin
                        n_count = r_count - 1'b1;
                    end
                end else if (requeue) begin
                    // The requeued thread is pushed and popped at once.
                    n_nxt  = r_cur;
                    n_head = next_ptr(r_head);
                end else begin
                    n_nxt = r_idle;
                end
                n_prev_term = r_cv && r_cur != r_idle && prev_st == ST_TERMINATED;
                n_state     = S_RUN;
            end
            S_RUN: begin
                if (slot_free) begin
                    st_we    = 1'b1;
                    st_wid   = r_nxt;
                    st_wdata = ST_RUNNING;
                    n_cur    = r_nxt;
                    n_cv     = 1'b1;
                    if (r_prev_term && r_cur != r_nxt) begin
                        n_pend = r_cur;
                        n_pv   = 1'b1;
                    end
                    out_sw  = 1'b1;
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        out_word                             = '0;
        out_word[OUT_RUN_LSB +: ID_W]        = n_cv ? n_cur : '0;
        out_word[OUT_RV_BIT]                 = n_cv;
        out_word[OUT_SW_BIT]                 = out_sw;
        out_word[OUT_RELV_BIT]               = r_rel_v;
        out_word[OUT_RELT_LSB +: ID_W]       = r_rel_t;
        out_word[OUT_REJ_BIT]                = out_rej;
        out_word[OUT_QC_LSB +: QC_W]         = QC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idle      <= '0;
            r_cur       <= '0;
            r_cv        <= 1'b0;
            r_pend      <= '0;
            r_pv        <= 1'b0;
            r_pre       <= 1'b0;
            r_depth     <= '0;
            r_act       <= 1'b0;
            r_force     <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_stv       <= '0;
            r_st_ok     <= 1'b0;
            r_due       <= 1'b0;
            r_rel_v     <= 1'b0;
            r_rel_t     <= '0;
            r_prev_term <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_cv        <= n_cv;
            r_pend      <= n_pend;
            r_pv        <= n_pv;
            r_pre       <= n_pre;
            r_depth     <= n_depth;
            r_act       <= n_act;
            r_force     <= n_force;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_due       <= n_due;
            r_rel_v     <= n_rel_v;
            r_rel_t     <= n_rel_t;
            r_prev_term <= n_prev_term;
            if (i_cfg_valid && o_cfg_ready) begin
                r_idle <= i_cfg_data;
            end
            if (st_we_ok) begin
                r_stv[TW'(st_wid)] <= 1'b1;
            end
            // An entry never written reads as free.
            if (st_re) begin
                r_st_ok <= in_range(st_rid) && r_stv[TW'(st_rid)];
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_tid <= n_tid;
        r_nxt <= n_nxt;
        if (load) begin
            r_out <= out_word;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out;

endmodule

// File: design/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks on the result stream of the thread scheduler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrts_checker #(
    parameter int NUM_THREADS = rrts_pkg::NUM_THREADS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [rrts_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    import rrts_pkg::*;

    // A stalled result word must stay on the bus unchanged.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result word changed while stalled")

    `ASSERT_IMPL(a_run_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[OUT_RV_BIT], o_m_axis_tdata[OUT_RUN_LSB +: ID_W] == '0, "running thread nonzero with no thread running")

    // A release only happens inside a scheduling decision.
    `ASSERT_IMPL(a_rel_switch, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[OUT_RELV_BIT], o_m_axis_tdata[OUT_SW_BIT] && o_m_axis_tdata[OUT_RV_BIT], "release without a switch")

    `ASSERT_IMPL(a_rel_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[OUT_RELV_BIT], o_m_axis_tdata[OUT_RELT_LSB +: ID_W] == '0, "release thread nonzero with no release")

    `ASSERT_IMPL(a_qcount, i_clk, i_rst_n, o_m_axis_tvalid, 32'(o_m_axis_tdata[OUT_QC_LSB +: QC_W]) <= 32'(NUM_THREADS), "queue count above thread count")

endmodule

bind round_robin_thread_scheduler_core rrts_checker #(
    .NUM_THREADS (NUM_THREADS)
) u_rrts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
